// File: hdl/pmfb_pkg.sv
// ============================================================================
// pmfb_pkg
// Shared types, op codes and sizes for the paged monochrome frame buffer.
// ============================================================================
package pmfb_pkg;

   // Default screen size
   localparam int DEF_SCREEN_WIDTH  = 84;
   localparam int DEF_SCREEN_HEIGHT = 48;

   // Page geometry: eight vertically stacked pixels per store byte
   localparam int PAGE_ROWS    = 8;
   localparam int BIT_W        = $clog2(PAGE_ROWS);
   localparam int BYTE_INDEX_W = 9;

   // Fill patterns
   localparam logic [7:0] FILL_ONES  = 8'hFF;
   localparam logic [7:0] FILL_ZEROS = 8'h00;

   // Op codes
   localparam logic [2:0] OP_WRITE  = 3'd0;
   localparam logic [2:0] OP_TOGGLE = 3'd1;
   localparam logic [2:0] OP_READ   = 3'd2;
   localparam logic [2:0] OP_FILL   = 3'd3;
   localparam logic [2:0] OP_BYTE   = 3'd4;

   typedef struct packed {
      logic [2:0]              op;
      logic [7:0]              pos_x;
      logic [7:0]              pos_y;
      logic                    color;
      logic [BYTE_INDEX_W-1:0] byte_index;
   } req_type;

   typedef struct packed {
      logic       pixel_value;
      logic [7:0] store_byte;
      logic       out_of_range;
   } rsp_type;

   // Controller to datapath commands
   typedef struct packed {
      logic load;    // capture the accepted item and read its byte
      logic sweep;   // write one byte of a store-wide sweep
      logic clear;   // sweep writes zero (post-reset clear)
      logic finish;  // write back the modified byte and load the result
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic req_fill;    // incoming item is a fill
      logic sweep_last;  // sweep is at the last store byte
   } sts_type;

endpackage

// File: hdl/pmfb_datapath.sv
// ============================================================================
// pmfb_datapath
// Address decode, frame store memory, read-modify-write and result register.
// ============================================================================
module pmfb_datapath #(
   parameter int SCREEN_WIDTH  = pmfb_pkg::DEF_SCREEN_WIDTH,
   parameter int SCREEN_HEIGHT = pmfb_pkg::DEF_SCREEN_HEIGHT
) (
   input  logic              clock,
   input  logic              reset,
   input  pmfb_pkg::req_type req_data,
   input  pmfb_pkg::cmd_type cmd,
   output pmfb_pkg::sts_type sts,
   output pmfb_pkg::rsp_type rsp_data
);
   import pmfb_pkg::*;

   localparam int PAGE_COUNT  = (SCREEN_HEIGHT + PAGE_ROWS - 1) / PAGE_ROWS;
   localparam int STORE_BYTES = SCREEN_WIDTH * PAGE_COUNT;
   localparam int ADDR_W      = $clog2(STORE_BYTES);
   localparam int CMP_W       = (ADDR_W >= BYTE_INDEX_W) ? ADDR_W + 1 : BYTE_INDEX_W + 1;

   // Frame store
   logic [7:0] mem [STORE_BYTES];

   // Item registers
   logic [2:0]       op_ff,    op_in;
   logic             color_ff, color_in;
   logic [BIT_W-1:0] bit_ff,   bit_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic             hit_ff,   hit_in;
   logic             oor_ff,   oor_in;
   logic [7:0]       rd_data_ff;
   logic [ADDR_W-1:0] cnt_ff,  cnt_in;
   rsp_type          rsp_ff,   rsp_in;

   // Decode helpers
   logic                  on_screen;
   logic [7-BIT_W:0]      page;
   logic [ADDR_W-1:0]     pix_addr;
   logic [CMP_W-1:0]      idx_ext;
   logic                  idx_ok;
   logic [ADDR_W-1:0]     look_addr;
   logic                  look_hit;
   logic                  look_oor;

   // Modify helpers
   logic [7:0]        mask;
   logic [7:0]        mod_byte;
   logic              mod_wr;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [7:0]        wr_data;

   // Locate the pixel byte and check bounds
   assign on_screen = ({1'b0, req_data.pos_x} < 9'(SCREEN_WIDTH)) &&
                      ({1'b0, req_data.pos_y} < 9'(SCREEN_HEIGHT));
   assign page      = req_data.pos_y[7:BIT_W];
   assign pix_addr  = ADDR_W'(req_data.pos_x) +
                      ADDR_W'(ADDR_W'(page) * ADDR_W'(SCREEN_WIDTH));
   assign idx_ext   = CMP_W'(req_data.byte_index);
   assign idx_ok    = idx_ext < CMP_W'(STORE_BYTES);

   always_comb begin
      look_addr = pix_addr;
      look_hit  = 1'b0;
      look_oor  = 1'b0;
      unique case (req_data.op) inside
         OP_WRITE, OP_TOGGLE, OP_READ: begin
            look_addr = pix_addr;
            look_hit  = on_screen;
            look_oor  = !on_screen;
         end
         OP_BYTE: begin
            look_addr = idx_ext[ADDR_W-1:0];
            look_hit  = idx_ok;
            look_oor  = !idx_ok;
         end
         default: begin
            look_addr = pix_addr;
            look_hit  = 1'b0;
            look_oor  = 1'b0;
         end
      endcase
   end

   // Capture the item on load
   always_comb begin
      op_in    = op_ff;
      color_in = color_ff;
      bit_in   = bit_ff;
      addr_in  = addr_ff;
      hit_in   = hit_ff;
      oor_in   = oor_ff;
      if (cmd.load) begin
         op_in    = req_data.op;
         color_in = req_data.color;
         bit_in   = req_data.pos_y[BIT_W-1:0];
         addr_in  = look_addr;
         hit_in   = look_hit;
         oor_in   = look_oor;
      end
   end

   // Advance the sweep counter; restart it on every load
   always_comb begin
      cnt_in = cnt_ff;
      if (cmd.load) begin
         cnt_in = '0;
      end else if (cmd.sweep) begin
         cnt_in = cnt_ff + ADDR_W'(1);
      end
   end

   assign sts.req_fill   = (req_data.op == OP_FILL);
   assign sts.sweep_last = (cnt_ff == ADDR_W'(STORE_BYTES - 1));

   // Modify the fetched byte
   assign mask = 8'(1) << bit_ff;

   always_comb begin
      mod_byte = rd_data_ff;
      mod_wr   = 1'b0;
      case (op_ff)
         OP_WRITE: begin
            mod_byte = color_ff ? (rd_data_ff | mask) : (rd_data_ff & ~mask);
            mod_wr   = hit_ff;
         end
         OP_TOGGLE: begin
            mod_byte = rd_data_ff ^ mask;
            mod_wr   = hit_ff;
         end
         default: begin
            mod_byte = rd_data_ff;
            mod_wr   = 1'b0;
         end
      endcase
   end

   // Select the write port source: sweep or write-back
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = addr_ff;
      wr_data = mod_byte;
      if (cmd.sweep) begin
         wr_en   = 1'b1;
         wr_addr = cnt_ff;
         wr_data = (cmd.clear || !color_ff) ? FILL_ZEROS : FILL_ONES;
      end else if (cmd.finish) begin
         wr_en   = mod_wr;
         wr_addr = addr_ff;
         wr_data = mod_byte;
      end
   end

   // Form the result
   always_comb begin
      rsp_in = rsp_ff;
      if (cmd.finish) begin
         rsp_in.pixel_value  = (op_ff == OP_READ) && hit_ff && (|(rd_data_ff & mask));
         rsp_in.store_byte   = ((op_ff == OP_BYTE) && hit_ff) ? rd_data_ff : FILL_ZEROS;
         rsp_in.out_of_range = oor_ff;
      end
   end

   assign rsp_data = rsp_ff;

   // Memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.load) begin
         rd_data_ff <= mem[look_addr];
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      op_ff    <= op_in;
      color_ff <= color_in;
      bit_ff   <= bit_in;
      addr_ff  <= addr_in;
      hit_ff   <= hit_in;
      oor_ff   <= oor_in;
      rsp_ff   <= rsp_in;
   end

   // Sweep counter starts at zero for the post-reset clear
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

endmodule

// File: hdl/pmfb_ctrl.sv
// ============================================================================
// pmfb_ctrl
// Sequencer: post-reset clear, item accept, fill sweep and result handoff.
// ============================================================================
module pmfb_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   input  pmfb_pkg::sts_type sts,
   output pmfb_pkg::cmd_type cmd
);
   import pmfb_pkg::*;

   localparam logic [1:0] ST_CLEAR  = 2'd0;
   localparam logic [1:0] ST_IDLE   = 2'd1;
   localparam logic [1:0] ST_FILL   = 2'd2;
   localparam logic [1:0] ST_MODIFY = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   // Output register can take a result when empty or being drained
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_stall  = 1'b1;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.sweep = 1'b1;
            cmd.clear = 1'b1;
            if (sts.sweep_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = sts.req_fill ? ST_FILL : ST_MODIFY;
            end
         end
         ST_FILL: begin
            cmd.sweep = 1'b1;
            if (sts.sweep_last) begin
               state_in = ST_MODIFY;
            end
         end
         ST_MODIFY: begin
            if (out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // Hold the result valid until transferred
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef SYNTHESIS
   a_finish_not_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result loaded over a held result");

   a_finish_shows_result: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> rsp_valid_ff)
      else $error("finished item did not raise rsp_valid");

   a_no_sweep_on_accept: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> (!cmd.sweep && !cmd.finish))
      else $error("accept overlaps a sweep or write-back");

   a_clear_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> (req_stall && !rsp_valid_ff))
      else $error("activity during post-reset clear");
`endif

endmodule

// File: hdl/paged_mono_framebuffer_engine.sv
// ============================================================================
// paged_mono_framebuffer_engine
// Page-addressed monochrome frame store with pixel and byte access ops.
// ============================================================================
// Usage:
//   Request channel (req_valid/req_stall/req_data) carries one op per transfer:
//   write, toggle or read a pixel, fill the store, or read one store byte.
//   Response channel (rsp_valid/rsp_stall/rsp_data) returns exactly one result
//   per request, in order.
//   Pixel and byte ops first accept the item and read the store byte, then
//   write back the modified byte and load the result register. The store
//   memory has one write port and one registered read port.
//   Fill walks the store one byte per cycle, then loads the result register.
//   The result register is a separate stage: a new request is accepted while
//   an earlier result still waits. If the receiver stalls, the finished item
//   holds in its write-back step and req_stall stays high until the
//   result register frees up.
//   After reset the block clears all STORE_BYTES bytes of the store to zero,
//   one byte per cycle, with req_stall high.
// ============================================================================
module paged_mono_framebuffer_engine #(
   parameter int SCREEN_WIDTH  = pmfb_pkg::DEF_SCREEN_WIDTH,
   parameter int SCREEN_HEIGHT = pmfb_pkg::DEF_SCREEN_HEIGHT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  pmfb_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output pmfb_pkg::rsp_type rsp_data
);
   import pmfb_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // Sequencer
   pmfb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Store and result datapath
   pmfb_datapath #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .sts      (sts),
      .rsp_data (rsp_data)
   );

endmodule
